// ===== rtl/pip_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types and constants for the point-in-polygon ray-cast block.
// ----------------------------------------------------------------------------
package pip_pkg;

    // Default coordinate width (signed Q8.8)
    localparam int COORD_BITS_DEF = 16;

    // Result stream payload width (inside flag padded to one byte)
    localparam int OUT_TDATA_W = 8;

    // Vertex count, saturating
    typedef logic [1:0] t_tally;

    localparam t_tally TALLY_ONE  = 2'd1;
    localparam t_tally TALLY_FULL = 2'd3;

endpackage : pip_pkg
`default_nettype wire

// ===== rtl/pip_edge.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pip_edge
// Even-odd ray test of one edge against a +x ray from the test point.
// ----------------------------------------------------------------------------
module pip_edge #(
    parameter int COORD_BITS = pip_pkg::COORD_BITS_DEF
) (
    input  wire logic signed [COORD_BITS-1:0] i_x0,
    input  wire logic signed [COORD_BITS-1:0] i_y0,
    input  wire logic signed [COORD_BITS-1:0] i_x1,
    input  wire logic signed [COORD_BITS-1:0] i_y1,
    input  wire logic signed [COORD_BITS-1:0] i_px,
    input  wire logic signed [COORD_BITS-1:0] i_py,
    output      logic                         o_hit
);
    import pip_pkg::*;

    localparam int W  = COORD_BITS;
    localparam int PW = 2 * W + 3;

    logic                swap;
    logic signed [W-1:0] ax, ay, bx, by, lo, hi;
    logic signed [W+1:0] py2, ay2, by2;
    logic signed [W:0]   dxp, dxr;
    logic signed [W+1:0] dyb, dyr;
    logic signed [PW-1:0] p1, p2;
    logic                off_span;

    // lower endpoint first; equal y keeps given order
    assign swap = (i_y0 > i_y1);
    assign ax   = swap ? i_x1 : i_x0;
    assign ay   = swap ? i_y1 : i_y0;
    assign bx   = swap ? i_x0 : i_x1;
    assign by   = swap ? i_y0 : i_y1;

    // doubled y; point on an endpoint's y is nudged up half an LSB
    assign py2 = {i_py[W-1], i_py, ((i_py == ay) || (i_py == by))};
    assign ay2 = {ay[W-1], ay, 1'b0};
    assign by2 = {by[W-1], by, 1'b0};

    assign lo = (ax < bx) ? ax : bx;
    assign hi = (ax < bx) ? bx : ax;

    assign off_span = (py2 > by2) || (py2 < ay2) || (i_px > hi);

    assign dxp = {i_px[W-1], i_px} - {ax[W-1], ax};
    assign dxr = {bx[W-1], bx} - {ax[W-1], ax};
    // both positive and below 2^(W+1) wherever they are used
    assign dyb = py2 - ay2;
    assign dyr = by2 - ay2;

    // same-sign case: blue >= red  <=>  dyb*dxr >= dyr*dxp
    assign p1 = $signed({{(W+1){dyb[W+1]}}, dyb}) * $signed({{(W+2){dxr[W]}}, dxr});
    assign p2 = $signed({{(W+1){dyr[W+1]}}, dyr}) * $signed({{(W+2){dxp[W]}}, dxp});

    always_comb begin
        if (off_span) begin
            o_hit = 1'b0;
        end else if (i_px < lo) begin
            o_hit = 1'b1;
        end else if (dxp == '0) begin
            o_hit = 1'b1;
        end else if (dxr == '0) begin
            o_hit = 1'b0;
        end else if (!dxp[W] && dxr[W]) begin
            o_hit = 1'b1;
        end else if (dxp[W] && !dxr[W]) begin
            o_hit = 1'b0;
        end else begin
            o_hit = (p1 >= p2);
        end
    end

endmodule : pip_edge
`default_nettype wire

// ===== rtl/point_in_polygon_ray_cast.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// point_in_polygon_ray_cast
// Path: an accepted vertex passes the input register, then the result register;
//   only the last vertex of a polygon gives a result.
// Throughput: one vertex per cycle, through two combinational edge testers
//   (two signed multiplies and a compare each), unless a last vertex waits on a held result.
// Reset: synchronous, active low; clears both stages and the polygon state.
// ----------------------------------------------------------------------------
module point_in_polygon_ray_cast #(
    parameter  int COORD_BITS = pip_pkg::COORD_BITS_DEF,
    localparam int TDATA_W    = ((4 * COORD_BITS + 7) / 8) * 8
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // vertex stream
    input  wire logic                            i_s_axis_tvalid,
    output      logic                            o_s_axis_tready,
    // tdata from bit 0: vertex_x, vertex_y, test_x, test_y, zero pad
    input  wire logic [TDATA_W-1:0]              i_s_axis_tdata,
    // tuser: first_vertex
    input  wire logic                            i_s_axis_tuser,
    // tlast: last_vertex
    input  wire logic                            i_s_axis_tlast,
    // result stream
    output      logic                            o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    // tdata from bit 0: inside_res, zero pad
    output      logic [pip_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    // tuser: short_polygon
    output      logic                            o_m_axis_tuser
);
    import pip_pkg::*;

    localparam int W = COORD_BITS;

    // ---------------- input register ----------------
    logic                r_in_valid;
    logic signed [W-1:0] r_vx, r_vy, r_tx, r_ty;
    logic                r_first, r_last;

    // ---------------- polygon state ----------------
    logic signed [W-1:0] r_start_x, r_start_y, r_prior_x, r_prior_y;
    logic                r_parity;
    t_tally              r_tally;

    logic signed [W-1:0] n_start_x, n_start_y;
    logic                n_parity;
    t_tally              n_tally;

    // ---------------- result register ----------------
    logic                r_out_valid;
    logic                r_inside, r_short;

    logic                w_out_free;
    logic                w_adv;
    logic                w_accept;
    logic                w_hit_run;    // prior -> current
    logic                w_hit_close;  // current -> first, on close
    logic                w_short;

    // A non-last vertex only touches polygon state, so it advances even while
    // a result waits; a last vertex needs the result slot.
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_adv           = r_in_valid && (!r_last || w_out_free);
    assign o_s_axis_tready = !r_in_valid || w_adv;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_vx    <= i_s_axis_tdata[W-1:0];
            r_vy    <= i_s_axis_tdata[2*W-1:W];
            r_tx    <= i_s_axis_tdata[3*W-1:2*W];
            r_ty    <= i_s_axis_tdata[4*W-1:3*W];
            r_first <= i_s_axis_tuser;
            r_last  <= i_s_axis_tlast;
        end
    end

    // Running edge: stored prior vertex to the current one.
    pip_edge #(
        .COORD_BITS (COORD_BITS)
    ) u_edge_run (
        .i_x0  (r_prior_x),
        .i_y0  (r_prior_y),
        .i_x1  (r_vx),
        .i_y1  (r_vy),
        .i_px  (r_tx),
        .i_py  (r_ty),
        .o_hit (w_hit_run)
    );

    // Closing edge: current vertex back to the first one.
    pip_edge #(
        .COORD_BITS (COORD_BITS)
    ) u_edge_close (
        .i_x0  (r_vx),
        .i_y0  (r_vy),
        .i_x1  (r_start_x),
        .i_y1  (r_start_y),
        .i_px  (r_tx),
        .i_py  (r_ty),
        .o_hit (w_hit_close)
    );

    // Next polygon state. A first-marked vertex restarts parity and count
    // and tests no edge; that includes the single-vertex polygon.
    always_comb begin
        n_start_x = r_start_x;
        n_start_y = r_start_y;
        n_parity  = r_parity;
        n_tally   = r_tally;
        if (r_first) begin
            n_start_x = r_vx;
            n_start_y = r_vy;
            n_parity  = 1'b0;
            n_tally   = TALLY_ONE;
        end else begin
            n_parity = r_parity ^ w_hit_run;
            if (r_tally != TALLY_FULL) begin
                n_tally = r_tally + TALLY_ONE;
            end
            if (r_last) begin
                n_parity = n_parity ^ w_hit_close;
            end
        end
    end

    assign w_short = (n_tally != TALLY_FULL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x <= '0;
            r_start_y <= '0;
            r_prior_x <= '0;
            r_prior_y <= '0;
            r_parity  <= 1'b0;
            r_tally   <= '0;
        end else if (w_adv) begin
            r_start_x <= n_start_x;
            r_start_y <= n_start_y;
            r_prior_x <= r_vx;
            r_prior_y <= r_vy;
            r_parity  <= n_parity;
            r_tally   <= n_tally;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && r_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_last) begin
            r_inside <= n_parity && !w_short;
            r_short  <= w_short;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W-1){1'b0}}, r_inside};
    assign o_m_axis_tuser  = r_short;

    // ---------------- assertions ----------------
    // short polygon never reports inside
    a_short_not_inside : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> !o_m_axis_tdata[0])
        else $error("short polygon reported inside");

    // a first-marked vertex restarts the count at one
    a_first_restarts : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && r_first |=> (r_tally == TALLY_ONE) && !r_parity)
        else $error("first vertex did not restart polygon state");

    // a closing vertex always lands in the result register
    a_close_emits : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && r_last |=> r_out_valid)
        else $error("closing vertex produced no result");

    // input stage never advances a last vertex onto a held result
    a_no_overwrite : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_m_axis_tready |-> !(w_adv && r_last))
        else $error("result overwritten while stalled");

endmodule : point_in_polygon_ray_cast
`default_nettype wire

// ===== tb/tb_point_in_polygon_ray_cast.sv =====
// ----------------------------------------------------------------------------
// tb_point_in_polygon_ray_cast
// Self-checking bench for the even-odd ray-cast point-in-polygon block.
// Vertices stream in one per transaction. A scoreboard model tracks the
// polygon state and predicts the inside/short verdicts typed rows do not fix. A directed table
// comes first, then randomized polygons. Both stream sides idle at random,
// and the result side is choked once so the vertex input backs up.
// ----------------------------------------------------------------------------
module tb_point_in_polygon_ray_cast;

    timeunit 1ns;
    timeprecision 1ps;

    import pip_pkg::*;

    localparam int CW           = COORD_BITS_DEF;
    localparam int IN_TDATA_W   = ((4 * CW + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 1200;
    localparam int CHOKE_AT     = 400;      // random vertex index that starts the choke
    localparam int CHOKE_CYCLES = 400;      // result side held off this long
    localparam int CHOKE_BURST  = 150;      // vertices sent back to back meanwhile
    localparam int DRAIN_CYCLES = 16;       // margin after the last verdict arrives
    localparam int CYCLE_LIMIT  = 1000000;

    typedef logic signed [CW-1:0] t_coord;

    // One vertex transaction; typed rows carry a hand-written verdict
    typedef struct {
        t_coord vx;
        t_coord vy;
        t_coord tx;
        t_coord ty;
        bit     first;
        bit     last;
        bit     typed;
        bit     exp_inside;
        bit     exp_short;
    } t_vertex_row;

    typedef struct packed {
        logic in_poly;
        logic short_poly;
    } t_poly_verdict;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata;     // vertex_x, vertex_y, test_x, test_y, pad
    logic                   i_s_axis_tuser;     // first_vertex
    logic                   i_s_axis_tlast;     // last_vertex
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;     // inside_res, pad
    logic                   o_m_axis_tuser;     // short_polygon

    point_in_polygon_ray_cast #(
        .COORD_BITS (CW)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // Scoreboard copy of the polygon state
    t_coord        anchor_x, anchor_y;      // first vertex of the polygon
    t_coord        prev_x, prev_y;          // vertex before the current one
    bit            crossing_odd;
    t_tally        vertices_seen;           // saturates at TALLY_FULL

    t_poly_verdict verdict_q[$];            // verdicts still owed by the block
    t_vertex_row   directed_rows[$];
    int            err_count;
    int            cycle_count;
    bit            choke_req;

    // ------------------------------------------------------------------------
    // Edge test against a ray from the point toward +x. y is handled doubled
    // so a point sitting on an endpoint's y can be lifted half an LSB exactly.
    // All products stay well below 2^40, so plain longint math is exact.
    // ------------------------------------------------------------------------
    function automatic bit ray_crosses(longint x0, longint y0, longint x1, longint y1,
                                       longint px, longint py);
        longint ax, ay, bx, by;
        longint py2, lo, hi, dxp, dxr, dyb, dyr;
        ax = x0; ay = y0; bx = x1; by = y1;
        // order endpoints by y, keep given order on a tie
        if (y0 > y1) begin
            ax = x1; ay = y1; bx = x0; by = y0;
        end
        py2 = 2 * py;
        if (py == ay || py == by)
            py2 = py2 + 1;
        lo = (ax < bx) ? ax : bx;
        hi = (ax < bx) ? bx : ax;
        // outside the y span (horizontal edges always land here) or right of box
        if (py2 > 2 * by || py2 < 2 * ay || px > hi)
            return 1'b0;
        if (px < lo)
            return 1'b1;
        dxp = px - ax;
        dxr = bx - ax;
        // a zero x run is the steepest slope possible
        if (dxp == 0)
            return 1'b1;
        if (dxr == 0)
            return 1'b0;
        dyb = py2 - 2 * ay;
        dyr = 2 * (by - ay);
        if (dxp > 0 && dxr < 0)
            return 1'b1;
        if (dxp < 0 && dxr > 0)
            return 1'b0;
        // same sign: compare slopes by cross multiplication of magnitudes
        if (dxp > 0)
            return (dyb * dxr) >= (dyr * dxp);
        return (dyr * (-dxp)) >= (dyb * (-dxr));
    endfunction

    // Advance the scoreboard state by one accepted vertex
    task automatic track_vertex(input t_vertex_row v, output bit emits,
                                output t_poly_verdict verdict);
        if (v.first) begin
            crossing_odd  = 1'b0;
            vertices_seen = TALLY_ONE;
            anchor_x      = v.vx;
            anchor_y      = v.vy;
        end else begin
            if (ray_crosses(prev_x, prev_y, v.vx, v.vy, v.tx, v.ty))
                crossing_odd = ~crossing_odd;
            if (vertices_seen != TALLY_FULL)
                vertices_seen = vertices_seen + 1'b1;
        end
        prev_x  = v.vx;
        prev_y  = v.vy;
        emits   = v.last;
        verdict = '0;
        if (v.last) begin
            // closing edge, current vertex back to the first one
            if (!v.first && ray_crosses(v.vx, v.vy, anchor_x, anchor_y, v.tx, v.ty))
                crossing_odd = ~crossing_odd;
            verdict.short_poly = (vertices_seen != TALLY_FULL);
            verdict.in_poly    = verdict.short_poly ? 1'b0 : crossing_odd;
        end
    endtask

    // Idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Coordinate near a center, with full-range and rail values mixed in
    function automatic t_coord rand_coord(int center);
        int r;
        int val;
        r = $urandom_range(0, 15);
        if (r == 0)
            return ($urandom_range(0, 1) != 0) ? t_coord'(32767) : t_coord'(-32768);
        if (r < 4)
            return t_coord'($urandom);
        val = center + int'($urandom_range(0, 4096)) - 2048;
        if (val > 32767)
            val = 32767;
        if (val < -32768)
            val = -32768;
        return t_coord'(val);
    endfunction

    function automatic t_vertex_row mk_row(int vx, int vy, int tx, int ty, bit first,
                                           bit last, bit typed = 1'b0,
                                           bit ins = 1'b0, bit shrt = 1'b0);
        t_vertex_row v;
        v.vx         = t_coord'(vx);
        v.vy         = t_coord'(vy);
        v.tx         = t_coord'(tx);
        v.ty         = t_coord'(ty);
        v.first      = first;
        v.last       = last;
        v.typed      = typed;
        v.exp_inside = ins;
        v.exp_short  = shrt;
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // Vertex driver. Entered right after an accepting edge (or after reset);
    // inputs move on the falling edge, tready is sampled on the rising edge.
    // With no gap tvalid simply stays high into the next transaction.
    // ------------------------------------------------------------------------
    task automatic send_vertex(input t_vertex_row v, input bit burst);
        int                    gap;
        bit                    emits;
        t_poly_verdict         verdict;
        logic [IN_TDATA_W-1:0] payload;
        gap = burst ? 0 : idle_len();
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        payload               = '0;
        payload[4*CW-1:0]     = {v.ty, v.tx, v.vy, v.vx};
        i_s_axis_tdata        = payload;
        i_s_axis_tuser        = v.first;
        i_s_axis_tlast        = v.last;
        i_s_axis_tvalid       = 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        // accepted: update the scoreboard, queue the verdict if one is due
        track_vertex(v, emits, verdict);
        if (emits) begin
            if (v.typed) begin
                verdict.in_poly    = v.exp_inside;
                verdict.short_poly = v.exp_short;
            end
            verdict_q.push_back(verdict);
        end
    endtask

    // ------------------------------------------------------------------------
    // Random polygons. Most are well formed (first mark on the opening vertex,
    // last mark on the closing one) so parity and tally go through all their
    // states; a few drop the first mark or scatter marks at random. Vertices
    // often share the test point's x or y, or the previous vertex's x or y,
    // to land on the nudge, vertical and horizontal corner cases.
    // ------------------------------------------------------------------------
    task automatic run_random_polygons(input int item_budget);
        int          sent;
        int          n;
        int          r;
        int          shape;
        int          center_x;
        int          center_y;
        int          burst_left;
        bit          burst_poly;
        t_coord      tx, ty, px, py;
        t_vertex_row v;
        sent       = 0;
        burst_left = 0;
        while (sent < item_budget) begin
            r = $urandom_range(0, 99);
            if (r < 5)
                n = 1;
            else if (r < 10)
                n = 2;
            else if (r < 97)
                n = $urandom_range(3, 8);
            else
                n = $urandom_range(9, 24);
            shape      = $urandom_range(0, 19);     // 0 no first mark, 1-2 noise
            center_x   = int'($urandom_range(0, 65535)) - 32768;
            center_y   = int'($urandom_range(0, 65535)) - 32768;
            tx         = rand_coord(center_x);
            ty         = rand_coord(center_y);
            px         = tx;
            py         = ty;
            burst_poly = ($urandom_range(0, 5) == 0);
            for (int i = 0; i < n; i++) begin
                v.vx = rand_coord(center_x);
                v.vy = rand_coord(center_y);
                case ($urandom_range(0, 9))
                    0: v.vy = ty;
                    1: v.vx = tx;
                    2: v.vy = py;
                    3: v.vx = px;
                    default: ;
                endcase
                // test point may move mid-polygon
                if ($urandom_range(0, 19) == 0) begin
                    tx = rand_coord(center_x);
                    ty = rand_coord(center_y);
                end
                v.tx = tx;
                v.ty = ty;
                if (shape == 0) begin
                    v.first = 1'b0;
                    v.last  = (i == n - 1);
                end else if (shape <= 2) begin
                    v.first = ($urandom_range(0, 3) == 0);
                    v.last  = ($urandom_range(0, 3) == 0);
                end else begin
                    v.first = (i == 0);
                    v.last  = (i == n - 1);
                end
                v.typed      = 1'b0;
                v.exp_inside = 1'b0;
                v.exp_short  = 1'b0;
                // one long choke on the result side while vertices keep coming
                if (sent == CHOKE_AT) begin
                    choke_req  = 1'b1;
                    burst_left = CHOKE_BURST;
                end
                send_vertex(v, burst_poly || burst_left > 0);
                if (burst_left > 0)
                    burst_left--;
                px = v.vx;
                py = v.vy;
                sent++;
            end
        end
    endtask

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("point_in_polygon_ray_cast test failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result-side pacing: alternating ready and stalled runs, mostly short,
    // with long ready stretches too. On request it holds tready low for a
    // counted stretch so the pipeline fills and pushes back on the input.
    // ------------------------------------------------------------------------
    initial begin : result_pacing
        int  run_left;
        int  choke_left;
        bit  choke_done;
        run_left        = 0;
        choke_left      = 0;
        choke_done      = 1'b0;
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (choke_req && !choke_done) begin
                choke_done = 1'b1;
                choke_left = CHOKE_CYCLES;
            end
            if (choke_left > 0) begin
                i_m_axis_tready = 1'b0;
                choke_left--;
            end else if (run_left > 0) begin
                run_left--;
            end else if ($urandom_range(0, 2) != 0) begin
                i_m_axis_tready = 1'b1;
                run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                        : $urandom_range(1, 20);
            end else begin
                i_m_axis_tready = 1'b0;
                run_left = idle_len();
            end
        end
    end

    // Result checker: every result transaction against the oldest verdict
    always @(posedge i_clk) begin : result_check
        t_poly_verdict want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (verdict_q.size() == 0) begin
                $error("result transaction with no polygon verdict pending");
                err_count++;
            end else begin
                want = verdict_q.pop_front();
                if (o_m_axis_tdata[0] !== want.in_poly) begin
                    $error("inside_res mismatch: expected %0b, got %0b",
                           want.in_poly, o_m_axis_tdata[0]);
                    err_count++;
                end
                if (o_m_axis_tuser !== want.short_poly) begin
                    $error("short_polygon mismatch: expected %0b, got %0b",
                           want.short_poly, o_m_axis_tuser);
                    err_count++;
                end
                if (o_m_axis_tdata[OUT_TDATA_W-1:1] !== '0) begin
                    $error("tdata_pad mismatch: expected 0, got %0h",
                           o_m_axis_tdata[OUT_TDATA_W-1:1]);
                    err_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        err_count       = 0;
        choke_req       = 1'b0;
        anchor_x        = '0;
        anchor_y        = '0;
        prev_x          = '0;
        prev_y          = '0;
        crossing_odd    = 1'b0;
        vertices_seen   = '0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = 1'b0;
        i_s_axis_tlast  = 1'b0;

        // Directed table. Typed verdicts only where obvious.
        // Unmarked vertex right after reset chains from the zero state: short
        directed_rows.push_back(mk_row(256, 256, 0, 0, 0, 1, 1, 0, 1));
        // first and last on one vertex: no edge tested, short
        directed_rows.push_back(mk_row(100, 100, 0, 0, 1, 1, 1, 0, 1));
        // two vertices: short
        directed_rows.push_back(mk_row(0, 0, 0, 0, 1, 0));
        directed_rows.push_back(mk_row(256, 0, 0, 0, 0, 1, 1, 0, 1));
        // triangle around the origin, point at the origin: inside
        directed_rows.push_back(mk_row(-256, -256, 0, 0, 1, 0));
        directed_rows.push_back(mk_row(256, -256, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(0, 256, 0, 0, 0, 1, 1, 1, 0));
        // same triangle, point far right of every edge: outside
        directed_rows.push_back(mk_row(-256, -256, 1000, 0, 1, 0));
        directed_rows.push_back(mk_row(256, -256, 1000, 0, 0, 0));
        directed_rows.push_back(mk_row(0, 256, 1000, 0, 0, 1, 1, 0, 0));
        // rail-to-rail triangle, point on a corner
        directed_rows.push_back(mk_row(-32768, -32768, 32767, -32768, 1, 0));
        directed_rows.push_back(mk_row(32767, -32768, 32767, -32768, 0, 0));
        directed_rows.push_back(mk_row(0, 32767, 32767, -32768, 0, 1));
        // square with vertical and horizontal sides, point on a corner
        directed_rows.push_back(mk_row(0, 0, 512, 512, 1, 0));
        directed_rows.push_back(mk_row(512, 0, 512, 512, 0, 0));
        directed_rows.push_back(mk_row(512, 512, 512, 512, 0, 0));
        directed_rows.push_back(mk_row(0, 512, 512, 512, 0, 1));
        // no first mark after a closed polygon: chain and tally carry over
        directed_rows.push_back(mk_row(-512, -512, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(512, -512, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(0, 512, 0, 0, 0, 1));
        // test point moves between vertices, ends on the opposite rails
        directed_rows.push_back(mk_row(-256, -256, 0, 0, 1, 0));
        directed_rows.push_back(mk_row(256, -256, 300, -100, 0, 0));
        directed_rows.push_back(mk_row(0, 256, -32768, 32767, 0, 1));
        // point level with a horizontal edge and on a lower endpoint's x
        directed_rows.push_back(mk_row(-256, 0, -256, 0, 1, 0));
        directed_rows.push_back(mk_row(256, 0, -256, 0, 0, 0));
        directed_rows.push_back(mk_row(0, 256, -256, 0, 0, 1));

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[k])
            send_vertex(directed_rows[k], 1'b0);

        run_random_polygons(RANDOM_ITEMS);

        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;

        // wait for every owed verdict, then let the pipeline settle
        while (verdict_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (verdict_q.size() != 0) begin
            $error("%0d polygon verdicts never arrived", verdict_q.size());
            err_count++;
        end

        if (err_count == 0)
            $display("point_in_polygon_ray_cast test passed");
        else
            $display("point_in_polygon_ray_cast test failed");
        $finish;
    end

endmodule

// ===== point_in_polygon_ray_cast.f =====
rtl/pip_pkg.sv
rtl/pip_edge.sv
rtl/point_in_polygon_ray_cast.sv
tb/tb_point_in_polygon_ray_cast.sv
